### hw/rtl/crse_pkg.sv
// ---------------------------------------------------------------------------
// crse_pkg: shared types and constants
// Widths, command codes and pipeline bookkeeping for the spline evaluator.
// ---------------------------------------------------------------------------
package crse_pkg;

    localparam int COORD_WIDTH = 24;               // control point, Q12.12
    localparam int T_FRAC_BITS = 16;               // segment parameter, Q0.16
    localparam int OUT_WIDTH   = 28;               // result, Q16.12
    localparam int W_WIDTH     = T_FRAC_BITS + 6;  // basis weight, units of 1/(2S)
    localparam int PROD_WIDTH  = W_WIDTH + COORD_WIDTH;
    localparam int SUM_WIDTH   = PROD_WIDTH + 2;
    localparam int CMD_WIDTH   = 2;
    localparam int NUM_STG     = 6;                // register stages, input to output

    localparam int IN_DATA_WIDTH  = T_FRAC_BITS + 8 * COORD_WIDTH;
    localparam int IN_DATA_BYTES  = (IN_DATA_WIDTH + 7) / 8;
    localparam int OUT_DATA_WIDTH = 2 * OUT_WIDTH;
    localparam int OUT_DATA_BYTES = (OUT_DATA_WIDTH + 7) / 8;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_POS = 2'd0,   // curve point
        CMD_VEL = 2'd1,   // first derivative
        CMD_ACC = 2'd2    // second derivative
    } t_cmd;

    typedef logic [COORD_WIDTH-1:0] t_coord;
    typedef t_coord [3:0]            t_quad;
    typedef logic [W_WIDTH-1:0]      t_wgt;
    typedef t_wgt [3:0]              t_wquad;
    typedef logic [T_FRAC_BITS-1:0]  t_frac;
    typedef logic [NUM_STG-1:0]      t_stg_en;    // load enable per stage

endpackage

### hw/rtl/crse_tpow.sv
// ---------------------------------------------------------------------------
// crse_tpow: powers of t
// Two multiply stages: t^2 then t^3, each truncated to Q0.16.
// ---------------------------------------------------------------------------
module crse_tpow (
    input  logic             i_clk,
    input  logic [1:0]       i_en,    // stage 1, stage 2
    input  crse_pkg::t_frac  i_t,
    output crse_pkg::t_frac  o_t,
    output crse_pkg::t_frac  o_t2,
    output crse_pkg::t_frac  o_t3
);
    import crse_pkg::*;

    t_frac                    r_t_s1;
    logic [2*T_FRAC_BITS-1:0] r_sq_s1;
    t_frac                    r_t_s2;
    t_frac                    r_t2_s2;
    logic [2*T_FRAC_BITS-1:0] r_cub_s2;

    logic [2*T_FRAC_BITS-1:0] n_sq;
    logic [2*T_FRAC_BITS-1:0] n_cub;
    t_frac                    sq_trunc;

    assign n_sq     = i_t * i_t;
    assign sq_trunc = r_sq_s1[T_FRAC_BITS +: T_FRAC_BITS];
    assign n_cub    = sq_trunc * r_t_s1;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_t_s1  <= i_t;
            r_sq_s1 <= n_sq;
        end
        if (i_en[1]) begin
            r_t_s2   <= r_t_s1;
            r_t2_s2  <= sq_trunc;
            r_cub_s2 <= n_cub;
        end
    end

    assign o_t  = r_t_s2;
    assign o_t2 = r_t2_s2;
    assign o_t3 = r_cub_s2[T_FRAC_BITS +: T_FRAC_BITS];

endmodule

### hw/rtl/crse_basis.sv
// ---------------------------------------------------------------------------
// crse_basis: basis weights
// Forms the four weights for position, first or second derivative (zero otherwise).
// ---------------------------------------------------------------------------
module crse_basis (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [crse_pkg::CMD_WIDTH-1:0] i_cmd,
    input  crse_pkg::t_frac               i_t,
    input  crse_pkg::t_frac               i_t2,
    input  crse_pkg::t_frac               i_t3,
    output crse_pkg::t_wquad              o_w
);
    import crse_pkg::*;

    localparam int ZPAD = W_WIDTH - T_FRAC_BITS;

    logic signed [W_WIDTH-1:0] a1, a2, a3, s_one;
    t_wquad                    n_w;
    t_wquad                    r_w;

    assign a1    = signed'({{ZPAD{1'b0}}, i_t});
    assign a2    = signed'({{ZPAD{1'b0}}, i_t2});
    assign a3    = signed'({{ZPAD{1'b0}}, i_t3});
    assign s_one = W_WIDTH'(1) << T_FRAC_BITS;

    always_comb begin
        case (i_cmd)
            CMD_POS: begin
                n_w[0] = W_WIDTH'(2 * a2 - a3 - a1);
                n_w[1] = W_WIDTH'(3 * a3 - 5 * a2 + 2 * s_one);
                n_w[2] = W_WIDTH'(4 * a2 + a1 - 3 * a3);
                n_w[3] = W_WIDTH'(a3 - a2);
            end
            CMD_VEL: begin
                n_w[0] = W_WIDTH'(4 * a1 - 3 * a2 - s_one);
                n_w[1] = W_WIDTH'(9 * a2 - 10 * a1);
                n_w[2] = W_WIDTH'(8 * a1 + s_one - 9 * a2);
                n_w[3] = W_WIDTH'(3 * a2 - 2 * a1);
            end
            CMD_ACC: begin
                n_w[0] = W_WIDTH'(4 * s_one - 6 * a1);
                n_w[1] = W_WIDTH'(18 * a1 - 10 * s_one);
                n_w[2] = W_WIDTH'(8 * s_one - 18 * a1);
                n_w[3] = W_WIDTH'(6 * a1 - 2 * s_one);
            end
            default: begin
                // unused selector: all weights zero gives a zero result
                n_w = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w <= n_w;
        end
    end

    assign o_w = r_w;

endmodule

### hw/rtl/crse_mac.sv
// ---------------------------------------------------------------------------
// crse_mac: weighted sums
// Eight products, pairwise sums, final sum and floor scaling to Q16.12.
// ---------------------------------------------------------------------------
module crse_mac (
    input  logic                          i_clk,
    input  logic [2:0]                    i_en,   // products, pair sums, output
    input  crse_pkg::t_wquad              i_w,
    input  crse_pkg::t_quad               i_px,
    input  crse_pkg::t_quad               i_py,
    output logic [crse_pkg::OUT_WIDTH-1:0] o_x,
    output logic [crse_pkg::OUT_WIDTH-1:0] o_y
);
    import crse_pkg::*;

    logic signed [PROD_WIDTH-1:0] r_prx [4];
    logic signed [PROD_WIDTH-1:0] r_pry [4];
    logic signed [SUM_WIDTH-1:0]  r_sx  [2];
    logic signed [SUM_WIDTH-1:0]  r_sy  [2];
    logic [OUT_WIDTH-1:0]         r_ox;
    logic [OUT_WIDTH-1:0]         r_oy;

    logic signed [SUM_WIDTH-1:0]  tot_x, tot_y;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int k = 0; k < 4; k++) begin
                r_prx[k] <= signed'(i_w[k]) * signed'(i_px[k]);
                r_pry[k] <= signed'(i_w[k]) * signed'(i_py[k]);
            end
        end
        if (i_en[1]) begin
            for (int k = 0; k < 2; k++) begin
                r_sx[k] <= SUM_WIDTH'(r_prx[2*k]) + SUM_WIDTH'(r_prx[2*k+1]);
                r_sy[k] <= SUM_WIDTH'(r_pry[2*k]) + SUM_WIDTH'(r_pry[2*k+1]);
            end
        end
        if (i_en[2]) begin
            r_ox <= tot_x[T_FRAC_BITS+1 +: OUT_WIDTH];
            r_oy <= tot_y[T_FRAC_BITS+1 +: OUT_WIDTH];
        end
    end

    // dropping the low bits of a two's complement sum floors it
    assign tot_x = r_sx[0] + r_sx[1];
    assign tot_y = r_sy[0] + r_sy[1];

    assign o_x = r_ox;
    assign o_y = r_oy;

endmodule

### hw/rtl/catmull_rom_spline_eval.sv
// ---------------------------------------------------------------------------
// catmull_rom_spline_eval: uniform Catmull-Rom segment evaluator, 2D
// Usage: one input transaction carries four Q12.12 control points, a Q0.16
// parameter t (s_axis_tdata) and a selector (s_axis_tuser: 0 point, 1 first
// derivative, 2 second derivative, 3 gives zero). One output transaction
// per input returns x and y in Q16.12 (m_axis_tdata), floor of the exact sum.
// Pipeline: t^2, t^3, weights, products, pair sums, final sum/output reg;
// six register stages, the first loaded at the accepting edge and the last
// driving m_axis. Throughput is one transaction per cycle while the receiver
// does not stall, set by the fully pipelined multipliers.
// Each stage carries a valid bit and loads when it is empty or the stage
// after it moves, so bubbles squeeze out and the input keeps taking
// transactions until every stage holds one. With the receiver stalled the
// output register holds its data and up to six transactions wait inside.
// s_axis_tready follows m_axis_tready combinationally through that chain.
// Reset (synchronous, active low) clears all valid bits; payload registers
// are not reset. There is no other state.
// ---------------------------------------------------------------------------
module catmull_rom_spline_eval (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // t_frac, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y (lowest first)
    input  logic [8*crse_pkg::IN_DATA_BYTES-1:0]     s_axis_tdata,
    // cmd
    input  logic [crse_pkg::CMD_WIDTH-1:0]           s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // out_x, out_y (lowest first)
    output logic [8*crse_pkg::OUT_DATA_BYTES-1:0]    m_axis_tdata
);
    import crse_pkg::*;

    logic [NUM_STG-1:0]   r_vld;
    logic [NUM_STG-1:0]   n_vld;    // valid bit each stage takes when it loads
    logic [NUM_STG:0]     adv;      // stage k may load; top bit is the sink
    t_stg_en              stg_en;

    logic [CMD_WIDTH-1:0] r_cmd_s1, r_cmd_s2;
    t_quad                in_px, in_py;
    t_quad                r_px_s1, r_py_s1, r_px_s2, r_py_s2, r_px_s3, r_py_s3;
    t_frac                in_t;

    t_frac                t_s2, t2_s2, t3_s2;
    t_wquad               w_s3;
    logic [OUT_WIDTH-1:0] out_x, out_y;

    // input field unpacking
    assign in_t = s_axis_tdata[T_FRAC_BITS-1:0];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            in_px[k] = s_axis_tdata[T_FRAC_BITS + (2*k)   * COORD_WIDTH +: COORD_WIDTH];
            in_py[k] = s_axis_tdata[T_FRAC_BITS + (2*k+1) * COORD_WIDTH +: COORD_WIDTH];
        end
    end

    // ready chain: a stage loads when empty or when its successor loads
    always_comb begin
        adv[NUM_STG] = m_axis_tready;
        for (int k = NUM_STG - 1; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end
    assign stg_en        = adv[NUM_STG-1:0];
    assign s_axis_tready = adv[0];

    assign n_vld = {r_vld[NUM_STG-2:0], s_axis_tvalid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NUM_STG; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // control points and selector ride along until the weights are ready
    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_cmd_s1 <= s_axis_tuser;
            r_px_s1  <= in_px;
            r_py_s1  <= in_py;
        end
        if (stg_en[1]) begin
            r_cmd_s2 <= r_cmd_s1;
            r_px_s2  <= r_px_s1;
            r_py_s2  <= r_py_s1;
        end
        if (stg_en[2]) begin
            r_px_s3 <= r_px_s2;
            r_py_s3 <= r_py_s2;
        end
    end

    crse_tpow u_tpow (
        .i_clk (i_clk),
        .i_en  (stg_en[1:0]),
        .i_t   (in_t),
        .o_t   (t_s2),
        .o_t2  (t2_s2),
        .o_t3  (t3_s2)
    );

    crse_basis u_basis (
        .i_clk (i_clk),
        .i_en  (stg_en[2]),
        .i_cmd (r_cmd_s2),
        .i_t   (t_s2),
        .i_t2  (t2_s2),
        .i_t3  (t3_s2),
        .o_w   (w_s3)
    );

    crse_mac u_mac (
        .i_clk (i_clk),
        .i_en  (stg_en[NUM_STG-1:3]),
        .i_w   (w_s3),
        .i_px  (r_px_s3),
        .i_py  (r_py_s3),
        .o_x   (out_x),
        .o_y   (out_y)
    );

    assign m_axis_tvalid = r_vld[NUM_STG-1];
    assign m_axis_tdata  = (8*OUT_DATA_BYTES)'({out_y, out_x});

endmodule

### hw/rtl/crse_chk.sv
// ---------------------------------------------------------------------------
// crse_chk: port checker
// Watches the evaluator's stream ports; bound to the top level.
// ---------------------------------------------------------------------------
module crse_chk (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  s_axis_tready,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [8*crse_pkg::OUT_DATA_BYTES-1:0] m_axis_tdata
);
    import crse_pkg::*;

    // output is empty the cycle after a reset cycle
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // a moving sink must let every stage move, so the input is ready
    a_ready_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

    // an empty output stage means the pipe cannot be full
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output changed");

endmodule

bind catmull_rom_spline_eval crse_chk u_crse_chk (.*);

### dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for catmull_rom_spline_eval
// Directed table first: closed-form cases carry their expected result, the
// rest go through a local spline predictor. A long random run with both
// stream sides idling and one long output hold-off follows. Every output
// transaction is compared field by field with the oldest expected x/y pair.
// ---------------------------------------------------------------------------
module tb_top import crse_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_WIDTH-1:0] CMD_NONE = 2'd3;  // unused selector, result is zero

    localparam int MAX_C          = 8388607;   // largest Q12.12 coordinate
    localparam int MIN_C          = -8388608;  // smallest Q12.12 coordinate
    localparam int IDLE_PCT       = 32;        // idle cycles per hundred, each side
    localparam int RAND_ITEMS     = 1750;
    localparam int HOLD_AT        = 300;       // random item that triggers the hold-off
    localparam int HOLD_CYCLES    = 80;        // far longer than the six-stage pipe
    localparam int QUIET_FROM     = 700;       // no idling on either side in this window
    localparam int QUIET_TO       = 1000;
    localparam int DRAIN_CYCLES   = 20;        // extra wait after the last expected result
    localparam int WATCHDOG_LIMIT = 1000;

    // One input transaction plus, where it is obvious, its expected result
    typedef struct packed {
        logic [CMD_WIDTH-1:0]   cmd;
        t_frac                  t;
        t_quad                  px;
        t_quad                  py;
        logic                   known;
        logic [OUT_WIDTH-1:0]   ex;
        logic [OUT_WIDTH-1:0]   ey;
    } spline_req_t;

    typedef struct packed {
        logic [OUT_WIDTH-1:0]   y;
        logic [OUT_WIDTH-1:0]   x;
    } xy_t;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Stream buses
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    // t_frac, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y (lowest first)
    logic [8*IN_DATA_BYTES-1:0]          s_axis_tdata  = '0;
    // cmd
    logic [CMD_WIDTH-1:0]                s_axis_tuser  = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    // out_x, out_y (lowest first)
    logic [8*OUT_DATA_BYTES-1:0]         m_axis_tdata;

    catmull_rom_spline_eval DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Bench state
    xy_t         pending_xy[$];      // expected x/y pairs, oldest first
    int          mismatch_cnt = 0;
    int          idle_cycles  = 0;   // cycles with no transaction on either side
    logic        no_gaps      = 1'b0;
    logic        hold_req     = 1'b0;
    spline_req_t dir_tab[$];

    // -----------------------------------------------------------------------
    // Predictor. Weights are integers in units of 1/(2S); the sum is formed
    // modulo 2^64, which is exact for the 45 low bits the result needs.
    // Floor division by 2S is then a plain right shift.
    // -----------------------------------------------------------------------
    function automatic xy_t spline_eval(logic [CMD_WIDTH-1:0] cmd, t_frac t,
                                        t_quad px, t_quad py);
        logic [63:0] tt;
        logic [63:0] s;
        logic [63:0] t2;
        logic [63:0] t3;
        logic [63:0] w [4];
        logic [63:0] sx;
        logic [63:0] sy;
        xy_t         r;
        int          i;

        tt = 64'(t);
        s  = 64'd1 << T_FRAC_BITS;
        t2 = (tt * tt) >> T_FRAC_BITS;
        t3 = (t2 * tt) >> T_FRAC_BITS;
        case (cmd)
            CMD_POS: begin
                w[0] = 2 * t2 - t3 - tt;
                w[1] = 3 * t3 - 5 * t2 + 2 * s;
                w[2] = 4 * t2 + tt - 3 * t3;
                w[3] = t3 - t2;
            end
            CMD_VEL: begin
                w[0] = 4 * tt - 3 * t2 - s;
                w[1] = 9 * t2 - 10 * tt;
                w[2] = 8 * tt + s - 9 * t2;
                w[3] = 3 * t2 - 2 * tt;
            end
            CMD_ACC: begin
                w[0] = 4 * s - 6 * tt;
                w[1] = 18 * tt - 10 * s;
                w[2] = 8 * s - 18 * tt;
                w[3] = 6 * tt - 2 * s;
            end
            default: begin
                return '0;
            end
        endcase
        sx = '0;
        sy = '0;
        for (i = 0; i < 4; i++) begin
            sx += w[i] * {{(64-COORD_WIDTH){px[i][COORD_WIDTH-1]}}, px[i]};
            sy += w[i] * {{(64-COORD_WIDTH){py[i][COORD_WIDTH-1]}}, py[i]};
        end
        sx = sx >> (T_FRAC_BITS + 1);
        sy = sy >> (T_FRAC_BITS + 1);
        r.x = sx[OUT_WIDTH-1:0];
        r.y = sy[OUT_WIDTH-1:0];
        return r;
    endfunction

    // Table row builder; ex/ey only matter when known is set
    function automatic spline_req_t mk_row(logic [CMD_WIDTH-1:0] cmd, int t,
                                           int x0, int y0, int x1, int y1,
                                           int x2, int y2, int x3, int y3,
                                           logic known, int ex, int ey);
        spline_req_t r;

        r.cmd   = cmd;
        r.t     = t[T_FRAC_BITS-1:0];
        r.px[0] = x0[COORD_WIDTH-1:0];
        r.py[0] = y0[COORD_WIDTH-1:0];
        r.px[1] = x1[COORD_WIDTH-1:0];
        r.py[1] = y1[COORD_WIDTH-1:0];
        r.px[2] = x2[COORD_WIDTH-1:0];
        r.py[2] = y2[COORD_WIDTH-1:0];
        r.px[3] = x3[COORD_WIDTH-1:0];
        r.py[3] = y3[COORD_WIDTH-1:0];
        r.known = known;
        r.ex    = ex[OUT_WIDTH-1:0];
        r.ey    = ey[OUT_WIDTH-1:0];
        return r;
    endfunction

    // Coordinates lean on the extremes and on small values, rest full range
    function automatic t_coord rand_coord();
        logic [31:0] v;
        int          sel;

        sel = $urandom_range(9);
        v   = $urandom;
        case (sel)
            0:       return MAX_C[COORD_WIDTH-1:0];
            1:       return MIN_C[COORD_WIDTH-1:0];
            2, 3, 4: return COORD_WIDTH'($signed(v[12:0]));
            default: return v[COORD_WIDTH-1:0];
        endcase
    endfunction

    function automatic spline_req_t rand_req();
        spline_req_t r;
        logic [31:0] v;
        int          i;

        v     = $urandom;
        r     = '0;
        r.cmd = ($urandom_range(99) < 5) ? CMD_NONE : CMD_WIDTH'($urandom_range(2));
        case ($urandom_range(9))
            0:       r.t = '0;
            1:       r.t = '1;
            default: r.t = v[T_FRAC_BITS-1:0];
        endcase
        for (i = 0; i < 4; i++) begin
            r.px[i] = rand_coord();
            r.py[i] = rand_coord();
        end
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Input side: optional idle cycles, then hold the transaction until
    // accepted. The expected pair is queued at the accepting edge.
    // -----------------------------------------------------------------------
    task automatic send_req(spline_req_t r);
        while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.cmd;
        s_axis_tdata  <= {r.py[3], r.px[3], r.py[2], r.px[2],
                          r.py[1], r.px[1], r.py[0], r.px[0], r.t};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        if (r.known)
            pending_xy.push_back({r.ey, r.ex});
        else
            pending_xy.push_back(spline_eval(r.cmd, r.t, r.px, r.py));
    endtask

    // -----------------------------------------------------------------------
    // Output side: random back-pressure, one long hold-off on request. The
    // hold-off is counted here so the sender keeps offering meanwhile and
    // the pipe fills up and stalls the input.
    // -----------------------------------------------------------------------
    initial begin
        int hold_left;

        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Mismatch reporting: first ten in full, the rest only counted
    task automatic report_mismatch(string field, logic [OUT_WIDTH-1:0] exp_v,
                                   logic [OUT_WIDTH-1:0] act_v);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, exp_v, act_v);
    endtask

    // Result checker, sampled at the rising edge
    always @(posedge i_clk) begin
        xy_t act_xy;
        xy_t exp_xy;

        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            act_xy = m_axis_tdata[2*OUT_WIDTH-1:0];
            if (pending_xy.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%0t: unexpected output transaction %h", $realtime, act_xy);
            end else begin
                exp_xy = pending_xy.pop_front();
                if (act_xy.x !== exp_xy.x)
                    report_mismatch("out_x", exp_xy.x, act_xy.x);
                if (act_xy.y !== exp_xy.y)
                    report_mismatch("out_y", exp_xy.y, act_xy.y);
            end
        end
    end

    // Watchdog: too long without any transaction on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial begin
        int n;

        // Closed forms used below: position at t=0 is P1; all-equal points
        // give that point back for position and zero for both derivatives;
        // first derivative at t=0 is (P2-P0)/2; the unused selector gives zero.
        dir_tab.push_back(mk_row(CMD_POS, 0, 100, -200, 4096, -4096, 8192, 12288, 0, 0,
                                 1'b1, 4096, -4096));
        dir_tab.push_back(mk_row(CMD_POS, 0, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C,
                                 MAX_C, MAX_C, 1'b1, MAX_C, MAX_C));
        dir_tab.push_back(mk_row(CMD_POS, 0, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C,
                                 MIN_C, MIN_C, 1'b1, MIN_C, MIN_C));
        dir_tab.push_back(mk_row(CMD_POS, 65535, 5000, -7000, 5000, -7000, 5000, -7000,
                                 5000, -7000, 1'b1, 5000, -7000));
        dir_tab.push_back(mk_row(CMD_VEL, 0, 0, 8192, 1234, -999, 8192, 0, 77, 31,
                                 1'b1, 4096, -4096));
        dir_tab.push_back(mk_row(CMD_VEL, 65535, MAX_C, MIN_C, MAX_C, MIN_C, MAX_C, MIN_C,
                                 MAX_C, MIN_C, 1'b1, 0, 0));
        dir_tab.push_back(mk_row(CMD_ACC, 12345, 5000, -7000, 5000, -7000, 5000, -7000,
                                 5000, -7000, 1'b1, 0, 0));
        dir_tab.push_back(mk_row(CMD_NONE, 0, MAX_C, MIN_C, MAX_C, MIN_C, MAX_C, MIN_C,
                                 MAX_C, MIN_C, 1'b1, 0, 0));
        dir_tab.push_back(mk_row(CMD_NONE, 65535, 1, -1, 2, -2, 3, -3, 4, -4, 1'b1, 0, 0));
        // Largest magnitudes: alternating extremes at several values of t
        dir_tab.push_back(mk_row(CMD_POS, 65535, MIN_C, MAX_C, MAX_C, MIN_C, MIN_C, MAX_C,
                                 MAX_C, MIN_C, 1'b0, 0, 0));
        dir_tab.push_back(mk_row(CMD_VEL, 65535, MIN_C, MAX_C, MAX_C, MIN_C, MIN_C, MAX_C,
                                 MAX_C, MIN_C, 1'b0, 0, 0));
        dir_tab.push_back(mk_row(CMD_ACC, 65535, MIN_C, MAX_C, MAX_C, MIN_C, MIN_C, MAX_C,
                                 MAX_C, MIN_C, 1'b0, 0, 0));
        dir_tab.push_back(mk_row(CMD_ACC, 0, MAX_C, MIN_C, MIN_C, MAX_C, MAX_C, MIN_C,
                                 MIN_C, MAX_C, 1'b0, 0, 0));
        dir_tab.push_back(mk_row(CMD_VEL, 32768, MAX_C, MIN_C, MIN_C, MAX_C, MAX_C, MIN_C,
                                 MIN_C, MAX_C, 1'b0, 0, 0));
        // Midpoint and single-step t, small coordinates for rounding of negatives
        dir_tab.push_back(mk_row(CMD_POS, 32768, -1, 1, -3, 3, 5, -5, -7, 7, 1'b0, 0, 0));
        dir_tab.push_back(mk_row(CMD_VEL, 1, -1, 1, -3, 3, 5, -5, -7, 7, 1'b0, 0, 0));
        dir_tab.push_back(mk_row(CMD_ACC, 1, -1, 1, -3, 3, 5, -5, -7, 7, 1'b0, 0, 0));
        dir_tab.push_back(mk_row(CMD_POS, 1, 4096, 0, -4096, 0, 4096, 0, -4096, 0,
                                 1'b0, 0, 0));
        // Alternating bit patterns in t and in the points
        dir_tab.push_back(mk_row(CMD_POS, 'hAAAA, 'h555555, 'h2AAAAA, 'h155555, 'h0AAAAA,
                                 -'h555556, -'h2AAAAB, 'h7FF000, -'h7FF000, 1'b0, 0, 0));
        dir_tab.push_back(mk_row(CMD_VEL, 'h5555, -'h555556, 'h0AAAAA, 'h2AAAAA, -'h155556,
                                 1, -1, 'h123456, -'h123456, 1'b0, 0, 0));
        dir_tab.push_back(mk_row(CMD_ACC, 'hAAAA, 'h7FFFFF, 0, 0, 'h7FFFFF, -1, 0, 0, -1,
                                 1'b0, 0, 0));

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i])
            send_req(dir_tab[i]);

        for (n = 0; n < RAND_ITEMS; n++) begin
            // Long output hold-off while the input keeps offering
            if (n == HOLD_AT)
                hold_req = 1'b1;
            no_gaps = (n >= QUIET_FROM && n < QUIET_TO);
            send_req(rand_req());
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        no_gaps = 1'b0;

        while (pending_xy.size() != 0)
            @(posedge i_clk);
        // Anything extra that shows up now counts as unexpected
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
